/* hdl/dqo_pkg.sv */
// Shared types and constants of the dual quadrature odometer.
// Used by the scaling unit and by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dqo_pkg;

  localparam int CIRC_W    = 16;  // Width of the circumference and divisor registers.
  localparam int DIST_W    = 32;  // Width of every distance result.
  localparam int CFG_IDX_W = 8;   // Width of the configuration register index.

  localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR  = 8'd1;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scale_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_CALC,
    TOP_HOLD
  } top_state_t;

endpackage

`default_nettype wire

/* hdl/dqo_scale.sv */
// Bit-serial scaling of one wheel count: |count| * circumference / pulses,
// then sign, truncation toward zero and saturation to 32 bits. Uses dqo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqo_scale
  import dqo_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire        [COUNT_WIDTH-1:0]  cnt,
  input  wire        [CIRC_W-1:0]       circ,
  input  wire        [CIRC_W-1:0]       ppr,
  output logic                          done,
  output logic signed [DIST_W-1:0]      distance
);

  localparam int PW     = COUNT_WIDTH + CIRC_W;
  localparam int QW     = (PW > DIST_W) ? PW : DIST_W;
  localparam int STEP_W = $clog2(PW + 1);

  scale_state_t state_r, state_nxt;

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [PW-1:0]      mcand_r, mcand_nxt;
  logic [CIRC_W-1:0]  mplier_r, mplier_nxt;
  logic [CIRC_W-1:0]  div_r, div_nxt;
  logic [CIRC_W-1:0]  rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;

  logic [COUNT_WIDTH-1:0] mag;
  logic [CIRC_W:0]        trial;
  logic                   fits;
  logic [QW-1:0]          quot;
  logic                   big;

  assign mag = cnt[COUNT_WIDTH-1] ? (~cnt + 1'b1) : cnt;

  // One restoring division step: the next dividend bit enters the remainder.
  assign trial = {rem_r, acc_r[PW-1]};
  assign fits  = trial >= {1'b0, div_r};

  assign quot = QW'({acc_r[PW-2:0], fits});
  assign big  = |quot[QW-1:DIST_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    step_r   <= step_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    dist_r   <= dist_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    dist_nxt   = dist_r;
    done_nxt   = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          neg_nxt    = cnt[COUNT_WIDTH-1];
          mcand_nxt  = PW'(mag);
          acc_nxt    = '0;
          mplier_nxt = circ;
          div_nxt    = (ppr == '0) ? CIRC_W'(1) : ppr;
          rem_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = SC_MUL;
        end
      end
      SC_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[CIRC_W-1:1]};
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(CIRC_W - 1)) begin
          step_nxt  = '0;
          state_nxt = SC_DIV;
        end
      end
      SC_DIV: begin
        // The quotient bits shift in behind the dividend in the same register.
        rem_nxt  = fits ? CIRC_W'(trial - {1'b0, div_r}) : trial[CIRC_W-1:0];
        acc_nxt  = {acc_r[PW-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(PW - 1)) begin
          if (neg_r) begin
            dist_nxt = big ? {1'b1, {(DIST_W-1){1'b0}}} : (~quot[DIST_W-1:0] + 1'b1);
          end else begin
            dist_nxt = big ? {1'b0, {(DIST_W-1){1'b1}}} : quot[DIST_W-1:0];
          end
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  assign done     = done_r;
  assign distance = dist_r;

endmodule

`default_nettype wire

/* hdl/dual_quadrature_odometer.sv */
// Top level of the dual quadrature odometer: encoder counting, configuration
// registers and the result register. Uses dqo_pkg and two dqo_scale units.
`timescale 1ns / 1ps
`default_nettype none

// A pin sample does not stall the input and produces no result. A read starts
// both wheel scaling units side by side; each multiplies the count magnitude
// by the circumference one bit per cycle and then divides by the pulses per
// rotation one quotient bit per cycle; both results and their mean are then
// loaded into the output register. The input stalls while a read is in the
// scaling units, and while a finished read waits for the output register to
// be free; samples are taken while an earlier result still waits.

module dual_quadrature_odometer
  import dqo_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_action,
  input  wire                         in_left_a,
  input  wire                         in_left_b,
  input  wire                         in_right_a,
  input  wire                         in_right_b,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic signed [DIST_W-1:0]    out_left_distance,
  output logic signed [DIST_W-1:0]    out_right_distance,
  output logic signed [DIST_W-1:0]    out_mean_distance,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire        [CFG_IDX_W-1:0]  cfg_index,
  input  wire        [CIRC_W-1:0]     cfg_data
);

  top_state_t state_r, state_nxt;

  logic [CIRC_W-1:0]      circ_r, ppr_r;
  logic [COUNT_WIDTH-1:0] lcnt_r, lcnt_nxt;
  logic [COUNT_WIDTH-1:0] rcnt_r, rcnt_nxt;
  logic                   la_prev_r, la_prev_nxt;
  logic                   ra_prev_r, ra_prev_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]      left_r, right_r, mean_r;
  logic                   load_out;

  logic                   in_xfer;
  logic                   start;
  logic                   left_done, right_done;
  logic signed [DIST_W-1:0] left_dist, right_dist;
  logic [DIST_W:0]        sum;
  logic [DIST_W:0]        sum_adj;

  assign in_stall  = (state_r != TOP_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign start     = in_xfer && in_action;
  assign cfg_ready = 1'b1;

  dqo_scale #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cnt      (lcnt_r),
    .circ     (circ_r),
    .ppr      (ppr_r),
    .done     (left_done),
    .distance (left_dist)
  );

  dqo_scale #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cnt      (rcnt_r),
    .circ     (circ_r),
    .ppr      (ppr_r),
    .done     (right_done),
    .distance (right_dist)
  );

  // The mean rounds toward zero, so a negative sum is nudged up by one first.
  assign sum     = {left_dist[DIST_W-1], left_dist} + {right_dist[DIST_W-1], right_dist};
  assign sum_adj = sum + {{DIST_W{1'b0}}, sum[DIST_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_IDLE;
      circ_r      <= CIRC_W'(1);
      ppr_r       <= CIRC_W'(1);
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      la_prev_r   <= 1'b0;
      ra_prev_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcnt_r      <= lcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      la_prev_r   <= la_prev_nxt;
      ra_prev_r   <= ra_prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CIRC) begin
          circ_r <= cfg_data;
        end else if (cfg_index == CFG_PPR) begin
          ppr_r <= cfg_data;
        end
      end
    end
    if (load_out) begin
      left_r  <= left_dist;
      right_r <= right_dist;
      mean_r  <= sum_adj[DIST_W:1];
    end
  end

  always_comb begin
    lcnt_nxt    = lcnt_r;
    rcnt_nxt    = rcnt_r;
    la_prev_nxt = la_prev_r;
    ra_prev_nxt = ra_prev_r;
    if (in_xfer && !in_action) begin
      if (in_left_a != la_prev_r) begin
        lcnt_nxt = (in_left_a == in_left_b) ? lcnt_r + 1'b1 : lcnt_r - 1'b1;
      end
      if (in_right_a != ra_prev_r) begin
        rcnt_nxt = (in_right_a != in_right_b) ? rcnt_r + 1'b1 : rcnt_r - 1'b1;
      end
      la_prev_nxt = in_left_a;
      ra_prev_nxt = in_right_a;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      TOP_IDLE: begin
        if (start) begin
          state_nxt = TOP_CALC;
        end
      end
      TOP_CALC: begin
        if (left_done && right_done) begin
          if (!out_valid_r || !out_stall) begin
            load_out      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = TOP_IDLE;
          end else begin
            state_nxt = TOP_HOLD;
          end
        end
      end
      TOP_HOLD: begin
        // The scaling units keep their results until the next start.
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = TOP_IDLE;
        end
      end
      default: begin
        state_nxt = TOP_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_left_distance  = left_r;
  assign out_right_distance = right_r;
  assign out_mean_distance  = mean_r;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the dual quadrature odometer: encoder edge counting,
// distance scaling at extreme settings, and the configuration registers.
// Depends on dqo_pkg and dual_quadrature_odometer.
`timescale 1ns / 1ps

module testbench;
  import dqo_pkg::*;

  localparam int COUNT_W       = 32;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 135;
  localparam int LARGE_COUNT   = 150;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = 8'hFF;
  localparam logic [CIRC_W-1:0]    CIRC_MAX      = 16'hFFFF;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DIST_W-1:0] left_d;
    logic signed [DIST_W-1:0] right_d;
    logic signed [DIST_W-1:0] mean_d;
  } distances_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_action = 1'b0;
  logic in_left_a = 1'b0;
  logic in_left_b = 1'b0;
  logic in_right_a = 1'b0;
  logic in_right_b = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CIRC_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic cfg_ready;
  logic signed [DIST_W-1:0] out_left_distance;
  logic signed [DIST_W-1:0] out_right_distance;
  logic signed [DIST_W-1:0] out_mean_distance;

  dual_quadrature_odometer #(
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_left_a(in_left_a),
    .in_left_b(in_left_b),
    .in_right_a(in_right_a),
    .in_right_b(in_right_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left_distance(out_left_distance),
    .out_right_distance(out_right_distance),
    .out_mean_distance(out_mean_distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Odometer state as the block should hold it.
  logic [CIRC_W-1:0]  circumference = 16'd1;
  logic [CIRC_W-1:0]  pulses_per_rev = 16'd1;
  logic [COUNT_W-1:0] left_count = '0;
  logic [COUNT_W-1:0] right_count = '0;
  logic               left_a_prev = 1'b0;
  logic               right_a_prev = 1'b0;

  distances_t pending_distances[$];

  int unsigned mismatch_count = 0;
  int unsigned reads_checked = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  bit          gaps_on = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached with %0d reads outstanding", $time,
               pending_distances.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: random-length stalls, short clear gaps, and long clear stretches.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 7))
        0: begin
          out_stall <= 1'b0;
          stall_run <= $urandom_range(50, 150);
        end
        1, 2: begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(1, 40);
        end
        default: begin
          out_stall <= 1'b0;
          stall_run <= $urandom_range(1, 6);
        end
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(posedge clk) begin
    distances_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_distances.size() == 0) begin
        $display("%0t ns: unexpected result transfer: left %0d, right %0d, mean %0d", $time,
                 out_left_distance, out_right_distance, out_mean_distance);
        mismatch_count++;
      end else begin
        want = pending_distances.pop_front();
        reads_checked++;
        if (out_left_distance !== want.left_d) begin
          $display("%0t ns: left_distance expected %0d, actual %0d", $time, want.left_d,
                   out_left_distance);
          mismatch_count++;
        end
        if (out_right_distance !== want.right_d) begin
          $display("%0t ns: right_distance expected %0d, actual %0d", $time, want.right_d,
                   out_right_distance);
          mismatch_count++;
        end
        if (out_mean_distance !== want.mean_d) begin
          $display("%0t ns: mean_distance expected %0d, actual %0d", $time, want.mean_d,
                   out_mean_distance);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic signed [DIST_W-1:0] scaled_distance(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] mag_c;
    logic [63:0] product;
    logic [63:0] quotient;
    logic [63:0] divisor;
    logic signed [DIST_W-1:0] dist_v;
    // Negating the most negative count gives back its own pattern, which is the
    // right magnitude when read as unsigned.
    mag_c = cnt[COUNT_W-1] ? -cnt : cnt;
    product = 64'(mag_c) * 64'(circumference);
    divisor = (pulses_per_rev == 0) ? 64'd1 : 64'(pulses_per_rev);
    quotient = product / divisor;
    if (cnt[COUNT_W-1]) begin
      if (quotient >= 64'h8000_0000) dist_v = DIST_MIN;
      else dist_v = -quotient[DIST_W-1:0];
    end else begin
      if (quotient > 64'h7FFF_FFFF) dist_v = DIST_MAX;
      else dist_v = quotient[DIST_W-1:0];
    end
    return dist_v;
  endfunction

  function automatic distances_t expected_distances();
    distances_t d;
    logic signed [DIST_W-1:0] l;
    logic signed [DIST_W-1:0] r;
    longint total;
    l = scaled_distance(left_count);
    r = scaled_distance(right_count);
    total = l;
    total = (total + r) / 2;
    d.left_d = l;
    d.right_d = r;
    d.mean_d = total[DIST_W-1:0];
    return d;
  endfunction

  function automatic void track_pins(input logic la, input logic lb, input logic ra,
                                     input logic rb);
    if (la != left_a_prev) left_count = (la == lb) ? left_count + 1'b1 : left_count - 1'b1;
    if (ra != right_a_prev) right_count = (ra != rb) ? right_count + 1'b1 : right_count - 1'b1;
    left_a_prev = la;
    right_a_prev = ra;
  endfunction

  task automatic send_item(input logic action, input logic la, input logic lb, input logic ra,
                           input logic rb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= action;
    in_left_a <= la;
    in_left_b <= lb;
    in_right_a <= ra;
    in_right_b <= rb;
    do @(posedge clk); while (in_stall);
    if (action == ACT_SAMPLE) track_pins(la, lb, ra, rb);
    else pending_distances.push_back(expected_distances());
    items_sent++;
  endtask

  // Registers may only change while nothing is in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CIRC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_CIRC) circumference = value;
    else if (index == CFG_PPR) pulses_per_rev = value;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CIRC_W-1:0] circ, input logic [CIRC_W-1:0] ppr);
    drain_results();
    write_register(CFG_CIRC, circ);
    write_register(CFG_PPR, ppr);
    settings_used++;
  endtask

  task automatic test_reset_state();
    // Pins on a read are ignored and must not update the stored A levels.
    send_item(ACT_READ, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_directions();
    send_item(ACT_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1);
    send_item(ACT_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(ACT_READ, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b1);
    send_item(ACT_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0);
    send_item(ACT_READ, 1'b0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_register_writes();
    set_geometry(16'd0, 16'd1);
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
    set_geometry(CIRC_MAX, 16'd0);
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
    set_geometry(16'd3, 16'd2);
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
    // Walk the left wheel backward past zero so the read scales a negative count.
    send_item(ACT_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_item(ACT_READ, 1'b1, 1'b1, 1'b0, 1'b0);
    drain_results();
    write_register(CFG_SPARE, CIRC_MAX);
    write_register(CFG_TOP_INDEX, CIRC_MAX);
    write_register(CFG_TOP_INDEX, 16'd0);
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_motion();
    logic [1:0] lphase;
    logic [1:0] rphase;
    int ldir;
    int rdir;
    int unsigned run_left;
    lphase = {left_a_prev, left_a_prev};
    rphase = {right_a_prev, right_a_prev};
    ldir = 0;
    rdir = 0;
    run_left = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 8)
        0: set_geometry(CIRC_MAX, 16'd1);
        1: set_geometry(16'd1, CIRC_MAX);
        2: set_geometry(CIRC_MAX, CIRC_MAX);
        3: set_geometry(16'd0, CIRC_W'($urandom));
        4: set_geometry(CIRC_W'($urandom_range(1, 65535)), 16'd0);
        5: set_geometry(16'd1, 16'd1);
        default: set_geometry(CIRC_W'($urandom_range(1, 65535)), CIRC_W'($urandom_range(1, 2000)));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(ACT_READ, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          // Noise: arbitrary pin levels that may break the quadrature sequence.
          send_item(ACT_SAMPLE, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 40);
            ldir = $urandom_range(0, 2) - 1;
            rdir = $urandom_range(0, 2) - 1;
          end
          run_left--;
          if ($urandom_range(0, 3) != 0) lphase = lphase + 2'(ldir);
          if ($urandom_range(0, 3) != 0) rphase = rphase + 2'(rdir);
          // Gray sequence: A = phase[1] ^ phase[0], B = phase[1].
          send_item(ACT_SAMPLE, lphase[1] ^ lphase[0], lphase[1], rphase[1] ^ rphase[0],
                    rphase[1]);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_large_counts();
    logic la;
    logic lb;
    logic ra;
    logic rb;
    set_geometry(CIRC_MAX, 16'd1);
    gaps_on = 1'b0;
    // Drive the left count up and the right count down so both scale to large distances.
    while ($signed(left_count) < LARGE_COUNT || $signed(right_count) > -LARGE_COUNT) begin
      la = left_a_prev;
      lb = 1'($urandom);
      ra = right_a_prev;
      rb = 1'($urandom);
      if ($signed(left_count) < LARGE_COUNT) begin
        la = ~left_a_prev;
        lb = la;
      end
      if ($signed(right_count) > -LARGE_COUNT) begin
        ra = ~right_a_prev;
        rb = ra;
      end
      send_item(ACT_SAMPLE, la, lb, ra, rb);
    end
    gaps_on = 1'b1;
    send_item(ACT_READ, 1'b0, 1'b0, 1'b0, 1'b0);
    set_geometry(CIRC_MAX, 16'd2);
    send_item(ACT_READ, 1'b1, 1'b1, 1'b1, 1'b1);
    set_geometry(CIRC_MAX, 16'd0);
    send_item(ACT_READ, 1'b0, 1'b1, 1'b0, 1'b1);
    set_geometry(16'd0, CIRC_MAX);
    send_item(ACT_READ, 1'b1, 1'b0, 1'b1, 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directions();
    test_register_writes();
    test_random_motion();
    test_large_counts();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d input transfers and %0d checked distance reads over %0d settings,",
             items_sent, reads_checked, settings_used);
    $display("including zero circumference, zero divisor and large scaled distances.");
    if (mismatch_count == 0 && pending_distances.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
